/* src/ttdb_pkg.sv */
// Shared types and constants for the touch tap debounce block with bus backoff.
// Holds the status codes, the configuration, state and result records.
// No dependencies.
`timescale 1ns / 1ps

package ttdb_pkg;

   // Result status codes
   typedef enum logic [2:0] {
      ST_ABSENT       = 3'd0,
      ST_BACKOFF_SKIP = 3'd1,
      ST_BUS_FAIL     = 3'd2,
      ST_FAIL_RECOVER = 3'd3,
      ST_NO_TOUCH     = 3'd4,
      ST_HELD         = 3'd5,
      ST_TAP          = 3'd6
   } status_type;

   // Poll outcome codes carried on the request tuser
   localparam logic REQ_BUS_FAIL = 1'b0;
   localparam logic REQ_FRAME    = 1'b1;

   // Configuration register indexes
   localparam int unsigned CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEVICE_PRESENT   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TAP_DEBOUNCE     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RELEASE_DEBOUNCE = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FAIL_THRESHOLD   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_RECOVERY_COOL    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_RECOVERY_BACKOFF = 3'd5;
   localparam int unsigned CSR_DATA_W = 16;

   // Reset values of the configuration registers
   localparam logic [15:0] TAP_DEBOUNCE_RST     = 16'd200;
   localparam logic [15:0] RELEASE_DEBOUNCE_RST = 16'd100;
   localparam logic [7:0]  FAIL_THRESHOLD_RST   = 8'd3;
   localparam logic [15:0] RECOVERY_COOL_RST    = 16'd1000;
   localparam logic [15:0] RECOVERY_BACKOFF_RST = 16'd100;

   // Touch decoding constants
   localparam logic [7:0] MAX_POINTS  = 8'd4;
   localparam logic [7:0] FAIL_SAT    = 8'd255;
   localparam int unsigned REQ_DATA_W = 72;
   localparam int unsigned RSP_DATA_W = 32;

   typedef struct packed {
      logic        device_present;
      logic [15:0] tap_debounce_ms;
      logic [15:0] release_debounce_ms;
      logic [7:0]  failure_threshold;
      logic [15:0] recovery_cooldown_ms;
      logic [15:0] recovery_backoff_ms;
   } cfg_type;

   typedef struct packed {
      logic        touch_active;
      logic [31:0] last_tap_ms;
      logic [31:0] last_release_ms;
      logic [7:0]  fail_count;
      logic [31:0] backoff_deadline_ms;
      logic [31:0] last_recovery_ms;
      logic        recovered_once;
   } state_type;

   typedef struct packed {
      logic        req_type;
      logic [31:0] now_ms;
      logic [7:0]  point_count;
      logic [7:0]  x_high_byte;
      logic [7:0]  x_low_byte;
      logic [7:0]  y_high_byte;
      logic [7:0]  y_low_byte;
   } item_type;

   typedef struct packed {
      status_type  status;
      logic        new_tap;
      logic        recover_request;
      logic [11:0] point_x;
      logic [11:0] point_y;
      logic        finger_down;
   } result_type;

endpackage

/* src/touch_tap_debounce_with_bus_backoff.sv */
// Top level: touch tap debouncer with bus-failure backoff.
// A request beat passes the input register, then the result register fed by
// one step of logic. Throughput: one beat per cycle while rsp_tready does not
// stall the result register; the tracker state is updated as an item moves
// into the result register. Synchronous active-high reset clears the pipeline
// valids and the tracker state and loads the register defaults.
`timescale 1ns / 1ps

module touch_tap_debounce_with_bus_backoff
   import ttdb_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // Request channel
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // tdata from bit 0: now_ms[31:0], point_count[7:0], x_high_byte[7:0],
   // x_low_byte[7:0], y_high_byte[7:0], y_low_byte[7:0]
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   // tuser: req_type
   input  logic                   req_tuser,
   // Response channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // tdata from bit 0: new_tap, recover_request, point_x[11:0], point_y[11:0],
   // finger_down, zero padding[4:0]
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   // tuser: status[2:0]
   output logic [2:0]             rsp_tuser,
   // Configuration write port
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type    cfg_ff, cfg_in;
   state_type  state_ff, state_in;
   item_type   item_ff;
   logic       item_valid_ff;
   result_type rsp_ff;
   logic       rsp_valid_ff;
   state_type  state_step;
   result_type result_step;
   logic       rsp_free;
   logic       advance;
   logic       accept;

   // Handshake: the result register takes a beat when empty or being drained
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = item_valid_ff && rsp_free;
   assign req_tready = !item_valid_ff || rsp_free;
   assign accept     = req_tvalid && req_tready;

   // Configuration register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_DEVICE_PRESENT:   cfg_in.device_present       = csr_wdata[0];
            CSR_TAP_DEBOUNCE:     cfg_in.tap_debounce_ms      = csr_wdata;
            CSR_RELEASE_DEBOUNCE: cfg_in.release_debounce_ms  = csr_wdata;
            CSR_FAIL_THRESHOLD:   cfg_in.failure_threshold    = csr_wdata[7:0];
            CSR_RECOVERY_COOL:    cfg_in.recovery_cooldown_ms = csr_wdata;
            CSR_RECOVERY_BACKOFF: cfg_in.recovery_backoff_ms  = csr_wdata;
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.device_present       <= 1'b0;
         cfg_ff.tap_debounce_ms      <= TAP_DEBOUNCE_RST;
         cfg_ff.release_debounce_ms  <= RELEASE_DEBOUNCE_RST;
         cfg_ff.failure_threshold    <= FAIL_THRESHOLD_RST;
         cfg_ff.recovery_cooldown_ms <= RECOVERY_COOL_RST;
         cfg_ff.recovery_backoff_ms  <= RECOVERY_BACKOFF_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_tready) begin
         item_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.req_type    <= req_tuser;
         item_ff.now_ms      <= req_tdata[31:0];
         item_ff.point_count <= req_tdata[39:32];
         item_ff.x_high_byte <= req_tdata[47:40];
         item_ff.x_low_byte  <= req_tdata[55:48];
         item_ff.y_high_byte <= req_tdata[63:56];
         item_ff.y_low_byte  <= req_tdata[71:64];
      end
   end

   // One step of the tracker
   ttdb_step u_step (
      .cfg       (cfg_ff),
      .state_cur (state_ff),
      .item      (item_ff),
      .state_nxt (state_step),
      .result    (result_step)
   );

   // Tracker state changes only when the item leaves the input register
   assign state_in = advance ? state_step : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_free) begin
         rsp_valid_ff <= item_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result_step;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tdata  = {5'd0, rsp_ff.finger_down, rsp_ff.point_y, rsp_ff.point_x,
                        rsp_ff.recover_request, rsp_ff.new_tap};

   // Checks on the result register and on the step feeding it
   a_tap_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.new_tap == (rsp_ff.status == ST_TAP)))
      else $error("new_tap disagrees with the status of the response beat");

   a_recover_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.recover_request == (rsp_ff.status == ST_FAIL_RECOVER)))
      else $error("recover_request disagrees with the status of the response beat");

   a_point_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status != ST_HELD && rsp_ff.status != ST_TAP)
      |-> (rsp_ff.point_x == 12'd0 && rsp_ff.point_y == 12'd0))
      else $error("coordinates reported without a touch");

   a_tap_needs_release: assert property (@(posedge clock) disable iff (reset)
      (advance && result_step.new_tap) |-> !state_ff.touch_active)
      else $error("tap reported while the finger was still down");

endmodule

/* src/ttdb_step.sv */
// Combinational evaluation of one poll item against the tracker state.
// Produces the result record and the state after the item.
// Depends on ttdb_pkg.
`timescale 1ns / 1ps

module ttdb_step
   import ttdb_pkg::*;
(
   input  cfg_type    cfg,
   input  state_type  state_cur,
   input  item_type   item,
   output state_type  state_nxt,
   output result_type result
);

   logic [31:0] deadline_diff;
   logic        in_backoff;
   logic [7:0]  fail_inc;
   logic [31:0] since_tap;
   logic [31:0] since_release;
   logic [31:0] since_recovery;
   logic        cooldown_ok;
   logic        recover_now;
   logic        touched;
   logic        tap_ok;

   // Wrap-safe time differences and the decisions taken from them
   always_comb begin
      deadline_diff  = item.now_ms - state_cur.backoff_deadline_ms;
      in_backoff     = (state_cur.backoff_deadline_ms != 32'd0) && deadline_diff[31];
      fail_inc       = (state_cur.fail_count == FAIL_SAT) ? FAIL_SAT
                                                          : state_cur.fail_count + 8'd1;
      since_recovery = item.now_ms - state_cur.last_recovery_ms;
      cooldown_ok    = since_recovery >= {16'd0, cfg.recovery_cooldown_ms};
      recover_now    = (fail_inc >= cfg.failure_threshold)
                       && (!state_cur.recovered_once || cooldown_ok);
      touched        = (item.point_count != 8'd0) && (item.point_count <= MAX_POINTS);
      since_tap      = item.now_ms - state_cur.last_tap_ms;
      since_release  = item.now_ms - state_cur.last_release_ms;
      tap_ok         = (since_tap >= {16'd0, cfg.tap_debounce_ms})
                       && !state_cur.touch_active
                       && (since_release >= {16'd0, cfg.release_debounce_ms});
   end

   // Result and next state
   always_comb begin
      state_nxt              = state_cur;
      result.status          = ST_ABSENT;
      result.new_tap         = 1'b0;
      result.recover_request = 1'b0;
      result.point_x         = 12'd0;
      result.point_y         = 12'd0;

      if (!cfg.device_present) begin
         result.status = ST_ABSENT;
      end else if (in_backoff) begin
         result.status = ST_BACKOFF_SKIP;
      end else begin
         // Any deadline that is still set here has expired
         state_nxt.backoff_deadline_ms = 32'd0;
         if (item.req_type == REQ_BUS_FAIL) begin
            state_nxt.fail_count = fail_inc;
            result.status        = ST_BUS_FAIL;
            if (recover_now) begin
               state_nxt.recovered_once      = 1'b1;
               state_nxt.last_recovery_ms    = item.now_ms;
               state_nxt.backoff_deadline_ms = item.now_ms
                                               + {16'd0, cfg.recovery_backoff_ms};
               state_nxt.fail_count          = 8'd0;
               result.status                 = ST_FAIL_RECOVER;
               result.recover_request        = 1'b1;
            end
         end else begin
            state_nxt.fail_count = 8'd0;
            if (!touched) begin
               if (state_cur.touch_active) begin
                  state_nxt.last_release_ms = item.now_ms;
                  state_nxt.touch_active    = 1'b0;
               end
               result.status = ST_NO_TOUCH;
            end else begin
               result.point_x = {item.x_high_byte[3:0], item.x_low_byte};
               result.point_y = {item.y_high_byte[3:0], item.y_low_byte};
               result.status  = ST_HELD;
               if (tap_ok) begin
                  state_nxt.last_tap_ms = item.now_ms;
                  result.status         = ST_TAP;
                  result.new_tap        = 1'b1;
               end
               state_nxt.touch_active = 1'b1;
            end
         end
      end

      result.finger_down = state_nxt.touch_active;
   end

endmodule

/* test/tb_touch_tap_debounce_with_bus_backoff.sv */
// Testbench for the touch tap debouncer with bus-failure backoff.
// Uses ttdb_pkg for the beat layouts, status codes and register indexes.
// Drives directed and random touch polls and checks every response beat.
`timescale 1ns / 1ps

module tb_touch_tap_debounce_with_bus_backoff;
   import ttdb_pkg::*;

   localparam int unsigned STALL_LIMIT = 2000;

   // Tracks the debouncer and backoff state and holds the outcomes still owed.
   class tap_tracker;
      cfg_type    cfg;
      state_type  st;
      result_type pending_outcomes[$];
      int         mismatches;

      function new();
         cfg.device_present       = 1'b0;
         cfg.tap_debounce_ms      = TAP_DEBOUNCE_RST;
         cfg.release_debounce_ms  = RELEASE_DEBOUNCE_RST;
         cfg.failure_threshold    = FAIL_THRESHOLD_RST;
         cfg.recovery_cooldown_ms = RECOVERY_COOL_RST;
         cfg.recovery_backoff_ms  = RECOVERY_BACKOFF_RST;
         st         = '0;
         mismatches = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_DEVICE_PRESENT:   cfg.device_present       = value[0];
            CSR_TAP_DEBOUNCE:     cfg.tap_debounce_ms      = value;
            CSR_RELEASE_DEBOUNCE: cfg.release_debounce_ms  = value;
            CSR_FAIL_THRESHOLD:   cfg.failure_threshold    = value[7:0];
            CSR_RECOVERY_COOL:    cfg.recovery_cooldown_ms = value;
            CSR_RECOVERY_BACKOFF: cfg.recovery_backoff_ms  = value;
            default: ;
         endcase
      endfunction

      // Wrap-safe: true when at least interval ms have passed since start.
      function bit elapsed_at_least(logic [31:0] now, logic [31:0] start,
                                    logic [15:0] interval);
         logic [31:0] diff;
         diff = now - start;
         return diff >= {16'd0, interval};
      endfunction

      // Wrap-safe: true while now lies before the deadline.
      function bit still_before(logic [31:0] now, logic [31:0] deadline);
         logic [31:0] diff;
         diff = now - deadline;
         return diff[31];
      endfunction

      // Works out the outcome of one poll and queues it; returns its status.
      function status_type note_poll(item_type it);
         result_type  r;
         logic [31:0] now;
         r        = '0;
         r.status = ST_ABSENT;
         now      = it.now_ms;
         if (cfg.device_present) begin
            if (st.backoff_deadline_ms != 0 && !still_before(now, st.backoff_deadline_ms))
               st.backoff_deadline_ms = '0;
            if (st.backoff_deadline_ms != 0) begin
               r.status = ST_BACKOFF_SKIP;
            end else if (it.req_type == REQ_BUS_FAIL) begin
               if (st.fail_count != FAIL_SAT)
                  st.fail_count = st.fail_count + 8'd1;
               r.status = ST_BUS_FAIL;
               if (st.fail_count >= cfg.failure_threshold &&
                   (!st.recovered_once ||
                    elapsed_at_least(now, st.last_recovery_ms, cfg.recovery_cooldown_ms))) begin
                  st.recovered_once      = 1'b1;
                  st.last_recovery_ms    = now;
                  st.backoff_deadline_ms = now + {16'd0, cfg.recovery_backoff_ms};
                  st.fail_count          = '0;
                  r.status               = ST_FAIL_RECOVER;
                  r.recover_request      = 1'b1;
               end
            end else begin
               st.fail_count = '0;
               if (it.point_count == 0 || it.point_count > MAX_POINTS) begin
                  // Lifting the finger records the release time.
                  if (st.touch_active) begin
                     st.last_release_ms = now;
                     st.touch_active    = 1'b0;
                  end
                  r.status = ST_NO_TOUCH;
               end else begin
                  r.point_x = {it.x_high_byte[3:0], it.x_low_byte};
                  r.point_y = {it.y_high_byte[3:0], it.y_low_byte};
                  r.status  = ST_HELD;
                  if (elapsed_at_least(now, st.last_tap_ms, cfg.tap_debounce_ms) &&
                      !st.touch_active &&
                      elapsed_at_least(now, st.last_release_ms, cfg.release_debounce_ms)) begin
                     st.last_tap_ms = now;
                     r.status       = ST_TAP;
                     r.new_tap      = 1'b1;
                  end
                  st.touch_active = 1'b1;
               end
            end
         end
         r.finger_down = st.touch_active;
         pending_outcomes.push_back(r);
         return r.status;
      endfunction

      function void flag(string field, int unsigned want, int unsigned got);
         if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            mismatches++;
         end
      endfunction

      function void check_outcome(result_type got);
         result_type want;
         if (pending_outcomes.size() == 0) begin
            $display("%0t: response beat with none expected, actual status %0d",
                     $time, got.status);
            mismatches++;
            return;
         end
         want = pending_outcomes.pop_front();
         flag("status", want.status, got.status);
         flag("new_tap", want.new_tap, got.new_tap);
         flag("recover_request", want.recover_request, got.recover_request);
         flag("point_x", want.point_x, got.point_x);
         flag("point_y", want.point_y, got.point_y);
         flag("finger_down", want.finger_down, got.finger_down);
      endfunction

      function int pending();
         return pending_outcomes.size();
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic                   req_tuser = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic [2:0]             rsp_tuser;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   tap_tracker  tracker = new();
   logic [31:0] poll_ms = '0;
   logic [15:0] backoff_now = RECOVERY_BACKOFF_RST;
   int          effective_polls = 0;
   bit          gaps_on = 1'b0;
   bit          stalls_on = 1'b0;
   int          stall_left = 0;
   int          quiet_cycles = 0;

   touch_tap_debounce_with_bus_backoff u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver: random stalls, mostly short, sometimes long.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_tready = 1'b0;
         stall_left--;
      end else if (stalls_on && $urandom_range(0, 99) < 25) begin
         rsp_tready = 1'b0;
         stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
                                                 : $urandom_range(8, 39);
      end else begin
         rsp_tready = 1'b1;
      end
   end

   // Response monitor: every accepted beat is checked against the oldest outcome.
   always @(posedge clock) begin
      result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status          = status_type'(rsp_tuser);
         got.new_tap         = rsp_tdata[0];
         got.recover_request = rsp_tdata[1];
         got.point_x         = rsp_tdata[13:2];
         got.point_y         = rsp_tdata[25:14];
         got.finger_down     = rsp_tdata[26];
         tracker.check_outcome(got);
      end
   end

   // Watchdog on cycles in which no beat moves on either side.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: timeout, no beat for %0d cycles", $time, STALL_LIMIT);
         $display("touch_tap_debounce_with_bus_backoff verification failed");
         $finish;
      end
   end

   function automatic int pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (!gaps_on || r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   // Time between polls: mostly short, now and then long or a jump anywhere.
   function automatic logic [31:0] pick_step();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 5)
         return 32'd0;
      if (r < 75)
         return $urandom_range(1, 40);
      if (r < 94)
         return $urandom_range(41, 400);
      if (r < 99)
         return $urandom_range(401, 70000);
      return $urandom();
   endfunction

   function automatic logic [7:0] pick_release_count();
      return ($urandom_range(0, 2) != 0) ? 8'd0 : 8'($urandom_range(5, 255));
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic poll_at(logic [31:0] at_ms, logic kind, logic [7:0] pts,
                          logic [31:0] coords);
      item_type   it;
      status_type st;
      int         gap;
      it.req_type    = kind;
      it.now_ms      = at_ms;
      it.point_count = pts;
      it.x_high_byte = coords[31:24];
      it.x_low_byte  = coords[23:16];
      it.y_high_byte = coords[15:8];
      it.y_low_byte  = coords[7:0];
      poll_ms = at_ms;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = it.req_type;
      req_tdata  = {it.y_low_byte, it.y_high_byte, it.x_low_byte, it.x_high_byte,
                    it.point_count, it.now_ms};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      st = tracker.note_poll(it);
      if (st != ST_ABSENT && st != ST_BACKOFF_SKIP)
         effective_polls++;
      @(negedge clock);
   endtask

   task automatic poll_after(logic [31:0] step, logic kind, logic [7:0] pts);
      poll_at(poll_ms + step, kind, pts, $urandom());
   endtask

   task automatic wait_drained();
      req_tvalid = 1'b0;
      while (tracker.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(posedge clock);
      tracker.write_reg(idx, value);
      @(negedge clock);
   endtask

   // All registers are rewritten with the pipeline empty.
   task automatic apply_settings(logic [15:0] present, logic [15:0] tap_ms,
                                 logic [15:0] rel_ms, logic [15:0] thr,
                                 logic [15:0] cool_ms, logic [15:0] backoff_ms);
      wait_drained();
      write_reg(CSR_DEVICE_PRESENT, present);
      write_reg(CSR_TAP_DEBOUNCE, tap_ms);
      write_reg(CSR_RELEASE_DEBOUNCE, rel_ms);
      write_reg(CSR_FAIL_THRESHOLD, thr);
      write_reg(CSR_RECOVERY_COOL, cool_ms);
      write_reg(CSR_RECOVERY_BACKOFF, backoff_ms);
      csr_we      = 1'b0;
      backoff_now = backoff_ms;
   endtask

   function automatic logic [15:0] pick_ms_setting(int unsigned upper);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 12)
         return 16'd0;
      if (r < 20)
         return 16'hFFFF;
      return 16'($urandom_range(0, upper));
   endfunction

   function automatic logic [15:0] pick_threshold();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 10)
         return 16'd0;
      if (r < 20)
         return 16'd255;
      return 16'($urandom_range(1, 5));
   endfunction

   // One random scenario: a touch gesture, a failure burst or noise.
   task automatic run_scenario();
      int unsigned pick;
      int          n;
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
         n = $urandom_range(1, 6);
         repeat (n) poll_after($urandom_range(0, 60), REQ_FRAME, 8'($urandom_range(1, 4)));
         n = $urandom_range(1, 3);
         repeat (n) poll_after($urandom_range(0, 60), REQ_FRAME, pick_release_count());
         poll_ms = poll_ms + pick_step();
      end else if (pick < 75) begin
         n = $urandom_range(1, 8);
         repeat (n) poll_after($urandom_range(0, 5), REQ_BUS_FAIL, 8'($urandom()));
         // A few polls may land inside a backoff; then, at random, step past it.
         n = $urandom_range(0, 2);
         repeat (n) poll_after($urandom_range(0, 30), 1'($urandom_range(0, 1)),
                               8'($urandom()));
         if ($urandom_range(0, 1))
            poll_ms = poll_ms + {16'd0, backoff_now} + $urandom_range(0, 20);
      end else begin
         poll_after(pick_step(), 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 99) < 3)
         wait_drained();
   endtask

   initial begin
      int start;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Device absent after reset: every poll is rejected.
      poll_at(32'd500, REQ_BUS_FAIL, 8'd1, $urandom());
      poll_at(32'd600, REQ_FRAME, 8'd1, $urandom());

      // Default timings with the device present.
      apply_settings(16'hFFFF, TAP_DEBOUNCE_RST, RELEASE_DEBOUNCE_RST,
                     {8'd0, FAIL_THRESHOLD_RST}, RECOVERY_COOL_RST, RECOVERY_BACKOFF_RST);
      poll_at(32'd1000, REQ_FRAME, 8'd1, 32'hFFFF_FFFF);
      poll_at(32'd1010, REQ_FRAME, 8'd4, 32'h0000_0000);
      poll_at(32'd1020, REQ_FRAME, 8'd0, $urandom());
      poll_at(32'd1070, REQ_FRAME, 8'd2, $urandom());
      poll_at(32'd1080, REQ_FRAME, 8'd5, $urandom());
      poll_at(32'd1400, REQ_FRAME, 8'd3, $urandom());
      poll_at(32'd1405, REQ_FRAME, 8'd255, $urandom());
      // A received frame clears the failure count even without touch.
      poll_at(32'd1406, REQ_BUS_FAIL, 8'd0, $urandom());
      poll_at(32'd1407, REQ_BUS_FAIL, 8'd0, $urandom());
      poll_at(32'd1408, REQ_FRAME, 8'd0, $urandom());
      poll_at(32'd1409, REQ_BUS_FAIL, 8'd0, $urandom());
      poll_at(32'd1410, REQ_BUS_FAIL, 8'd0, $urandom());
      poll_at(32'd1411, REQ_BUS_FAIL, 8'd0, $urandom());
      // Inside the backoff, then exactly at the deadline.
      poll_at(32'd1420, REQ_FRAME, 8'd1, $urandom());
      poll_at(32'd1511, REQ_FRAME, 8'd1, $urandom());
      // Cooldown holds off a second recovery.
      poll_at(32'd1520, REQ_BUS_FAIL, 8'd0, $urandom());
      poll_at(32'd1521, REQ_BUS_FAIL, 8'd0, $urandom());
      poll_at(32'd1522, REQ_BUS_FAIL, 8'd0, $urandom());
      poll_at(32'd1523, REQ_BUS_FAIL, 8'd0, $urandom());
      poll_at(32'd1524, REQ_FRAME, 8'd0, $urandom());
      // Recovery whose deadline wraps to zero, so no backoff follows.
      poll_at(32'hFFFF_FF9A, REQ_BUS_FAIL, 8'd0, $urandom());
      poll_at(32'hFFFF_FF9B, REQ_BUS_FAIL, 8'd0, $urandom());
      poll_at(32'hFFFF_FF9C, REQ_BUS_FAIL, 8'd0, $urandom());
      poll_at(32'hFFFF_FF9D, REQ_FRAME, 8'd1, $urandom());
      poll_at(32'h0000_0010, REQ_FRAME, 8'd1, $urandom());

      // Zero threshold, zero debounces and cooldown, longest backoff.
      apply_settings(16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF);
      poll_after(32'd1, REQ_BUS_FAIL, 8'd0);
      poll_after(32'd100, REQ_FRAME, 8'd1);
      poll_after(32'd65435, REQ_FRAME, 8'd1);
      poll_after(32'd0, REQ_FRAME, 8'd0);
      poll_after(32'd0, REQ_FRAME, 8'd2);
      poll_after(32'd0, REQ_BUS_FAIL, 8'd0);

      // Long failure run under the longest cooldown: the count saturates.
      apply_settings(16'd1, 16'hFFFF, 16'hFFFF, 16'd3, 16'hFFFF, 16'd0);
      gaps_on   = 1'b1;
      stalls_on = 1'b1;
      poll_ms   = poll_ms + 32'd70000;
      repeat (265) poll_after(32'd1, REQ_BUS_FAIL, 8'($urandom()));
      poll_after(32'd1, REQ_FRAME, 8'd1);

      // Random phases, each with its own settings and idling pattern.
      for (int phase = 0; phase < 6; phase++) begin
         apply_settings(16'd1, pick_ms_setting(300), pick_ms_setting(200), pick_threshold(),
                        pick_ms_setting(2000), pick_ms_setting(300));
         gaps_on   = (phase != 0) && ($urandom_range(0, 3) != 0);
         stalls_on = (phase != 0) && ($urandom_range(0, 3) != 0);
         start     = effective_polls;
         while (effective_polls - start < 100) run_scenario();
         if (phase == 2) begin
            // Device withdrawn for a moment: state must survive untouched.
            apply_settings(16'd0, 16'd150, 16'd80, 16'd2, 16'd500, 16'd50);
            repeat (5) poll_after(pick_step(), 1'($urandom_range(0, 1)),
                                  8'($urandom_range(0, 255)));
         end
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.pending() == 0)
         $display("touch_tap_debounce_with_bus_backoff verification clean");
      else
         $display("touch_tap_debounce_with_bus_backoff verification failed");
      $finish;
   end

endmodule
